// File: rtl/core/prac_pkg.sv
// prac_pkg: shared types, constants and the arctangent table for the
// point rotate about center core. No dependencies.
`default_nettype none

package prac_pkg;

	localparam int DP_W     = 64;   // CORDIC datapath width
	localparam int FRAC_W   = 60;   // coord width plus guard bits
	localparam int ANGLE_W  = 32;   // binary turns
	localparam int Z_W      = 32;   // residual angle
	localparam int GAIN_LAT = 6;    // gain lane depth incl. output register

	localparam logic [31:0] GAIN_Q32    = 32'd2608131496;
	localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

	typedef struct packed {
		logic valid;
		logic is_null;
	} prac_tag_t;

	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} prac_quad_t;

	// round(atan(2^-i) * 2^32 / (2*pi))
	function automatic logic [31:0] prac_atan(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'd536870912;
			1:  v = 32'd316933406;
			2:  v = 32'd167458907;
			3:  v = 32'd85004756;
			4:  v = 32'd42667331;
			5:  v = 32'd21354465;
			6:  v = 32'd10679838;
			7:  v = 32'd5340245;
			8:  v = 32'd2670163;
			9:  v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41721;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/prac_prerot.sv
// prac_prerot: offset from center, exact quarter-turn pre-rotation and
// residual angle. Depends on prac_pkg.
`default_nettype none

module prac_prerot import prac_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic                          in_null,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic signed [COORD_WIDTH-1:0] center_x,
	input  wire logic signed [COORD_WIDTH-1:0] center_y,
	input  wire logic        [ANGLE_W-1:0]     rotation_angle,
	output logic signed [DP_W-1:0]             x_s1,
	output logic signed [DP_W-1:0]             y_s1,
	output logic signed [Z_W-1:0]              z_s1,
	output prac_tag_t                          tag_s1,
	output logic signed [COORD_WIDTH-1:0]      base_x_s1,
	output logic signed [COORD_WIDTH-1:0]      base_y_s1
);

	localparam int GUARD = FRAC_W - COORD_WIDTH;

	logic signed [COORD_WIDTH:0] dx, dy, rx, ry;
	logic        [ANGLE_W-1:0]   a;
	prac_quad_t                  quad;
	logic signed [DP_W-1:0]      x_n, y_n;
	logic signed [Z_W-1:0]       z_n;

	always_comb begin
		dx   = (COORD_WIDTH+1)'(point_x) - (COORD_WIDTH+1)'(center_x);
		dy   = (COORD_WIDTH+1)'(point_y) - (COORD_WIDTH+1)'(center_y);
		a    = rotation_angle + EIGHTH_TURN;
		quad = prac_quad_t'(a[ANGLE_W-1 -: 2]);
		case (quad)
			QUAD_0: begin
				rx = dx;
				ry = dy;
			end
			QUAD_90: begin
				rx = -dy;
				ry = dx;
			end
			QUAD_180: begin
				rx = -dx;
				ry = -dy;
			end
			QUAD_270: begin
				rx = dy;
				ry = -dx;
			end
			default: begin
				rx = dx;
				ry = dy;
			end
		endcase
		x_n = DP_W'(rx) <<< GUARD;
		y_n = DP_W'(ry) <<< GUARD;
		z_n = $signed({2'b00, a[ANGLE_W-3:0]} - EIGHTH_TURN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.valid   <= in_valid;
			tag_s1.is_null <= in_null;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1      <= x_n;
			y_s1      <= y_n;
			z_s1      <= z_n;
			base_x_s1 <= in_null ? point_x : center_x;
			base_y_s1 <= in_null ? point_y : center_y;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/prac_cell.sv
// prac_cell: one CORDIC rotation cell with a fixed shift and arctangent.
// Depends on prac_pkg.
`default_nettype none

module prac_cell import prac_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int IDX         = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic signed [DP_W-1:0]        x_in,
	input  wire logic signed [DP_W-1:0]        y_in,
	input  wire logic signed [Z_W-1:0]         z_in,
	input  wire prac_tag_t                     tag_in,
	input  wire logic signed [COORD_WIDTH-1:0] base_x_in,
	input  wire logic signed [COORD_WIDTH-1:0] base_y_in,
	output logic signed [DP_W-1:0]             x_q,
	output logic signed [DP_W-1:0]             y_q,
	output logic signed [Z_W-1:0]              z_q,
	output prac_tag_t                          tag_q,
	output logic signed [COORD_WIDTH-1:0]      base_x_q,
	output logic signed [COORD_WIDTH-1:0]      base_y_q
);

	localparam logic [31:0] ATAN = prac_atan(IDX);

	logic signed [DP_W-1:0] xs, ys;

	assign xs = x_in >>> IDX;
	assign ys = y_in >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[Z_W-1]) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - $signed(ATAN);
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + $signed(ATAN);
			end
			base_x_q <= base_x_in;
			base_y_q <= base_y_in;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/prac_gain_lane.sv
// prac_gain_lane: gain compensation, rounding, center add-back and clamp
// for one coordinate, or base pass-through for a null point. Depends on prac_pkg.
`default_nettype none

module prac_gain_lane import prac_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [DP_W-1:0]        v_in,
	input  wire logic signed [COORD_WIDTH-1:0] base_in,
	input  wire logic                          null_in,
	output logic signed [COORD_WIDTH-1:0]      val_q,
	output logic                               hit_q
);

	localparam int GUARD = FRAC_W - COORD_WIDTH;
	localparam int RW    = COORD_WIDTH + 3;
	localparam int SW    = COORD_WIDTH + 5;
	localparam logic [DP_W-1:0] HALF = DP_W'(1) << (GUARD - 1);
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic [DP_W-1:0]               mag_s1, plo_s2, phi_s2, sum_s3;
	logic [RW-1:0]                 r_s4;
	logic signed [SW-1:0]          tot_s5;
	logic                          neg_s1, neg_s2, neg_s3, neg_s4;
	logic                          null_s1, null_s2, null_s3, null_s4, null_s5;
	logic signed [COORD_WIDTH-1:0] base_s1, base_s2, base_s3, base_s4, base_s5;

	logic [DP_W-1:0]      rnd;
	logic signed [SW-1:0] base_ext, r_ext;
	logic                 in_range;

	always_comb begin
		rnd      = sum_s3 + HALF;
		base_ext = SW'(base_s4);
		r_ext    = $signed(SW'(r_s4));
		in_range = (&tot_s5[SW-1:COORD_WIDTH-1]) || !(|tot_s5[SW-1:COORD_WIDTH-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= v_in[DP_W-1];
			mag_s1  <= v_in[DP_W-1] ? DP_W'(-v_in) : DP_W'(v_in);
			null_s1 <= null_in;
			base_s1 <= base_in;

			plo_s2  <= {32'd0, mag_s1[31:0]} * {32'd0, GAIN_Q32};
			phi_s2  <= {32'd0, mag_s1[DP_W-1:32]} * {32'd0, GAIN_Q32};
			neg_s2  <= neg_s1;
			null_s2 <= null_s1;
			base_s2 <= base_s1;

			sum_s3  <= phi_s2 + (plo_s2 >> 32);
			neg_s3  <= neg_s2;
			null_s3 <= null_s2;
			base_s3 <= base_s2;

			r_s4    <= rnd[GUARD +: RW];
			neg_s4  <= neg_s3;
			null_s4 <= null_s3;
			base_s4 <= base_s3;

			tot_s5  <= neg_s4 ? base_ext - r_ext : base_ext + r_ext;
			null_s5 <= null_s4;
			base_s5 <= base_s4;

			if (null_s5) begin
				val_q <= base_s5;
				hit_q <= 1'b0;
			end else if (in_range) begin
				val_q <= tot_s5[COORD_WIDTH-1:0];
				hit_q <= 1'b0;
			end else begin
				val_q <= tot_s5[SW-1] ? CMIN : CMAX;
				hit_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/point_rotate_about_center_core.sv
// point_rotate_about_center_core: top level; input skid, pre-rotation,
// CORDIC cell chain and gain lanes. Depends on prac_pkg and all prac_* modules.
//
//  channel  | dir | tdata                                          | tuser
//  s_axis   | in  | point_x, point_y, center_x, center_y, angle    | point_is_null
//  m_axis   | out | rotated_x, rotated_y                           | result_is_null, saturated
//
// One request per cycle sustained while the output is taken; the path is
// pre-rotation, one register per CORDIC cell, then six gain/clamp stages.
// arst_n clears valid state only; no clearing pass.
// The whole pipeline stalls when the output holds an untaken request; a
// one-entry skid keeps s_axis_tready registered.
`default_nettype none

module point_rotate_about_center_core import prac_pkg::*; #(
	parameter int COORD_WIDTH   = 32,
	parameter int CORDIC_STAGES = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	// point_x, point_y, center_x, center_y, rotation_angle, zero pad
	input  wire logic [((4*COORD_WIDTH+ANGLE_W+7)/8)*8-1:0] s_axis_tdata,
	// point_is_null
	input  wire logic                    s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	// rotated_x, rotated_y, zero pad
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// result_is_null, saturated
	output logic [1:0]                   m_axis_tuser
);

	localparam int IN_W  = ((4*COORD_WIDTH + ANGLE_W + 7) / 8) * 8;
	localparam int OUT_W = ((2*COORD_WIDTH + 7) / 8) * 8;
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic            skid_valid_q;
	logic [IN_W-1:0] skid_data_q;
	logic            skid_null_q;
	logic            en, accept, feed_valid, feed_null;
	logic [IN_W-1:0] feed_data;

	logic signed [DP_W-1:0]        x_c [0:CORDIC_STAGES];
	logic signed [DP_W-1:0]        y_c [0:CORDIC_STAGES];
	logic signed [Z_W-1:0]         z_c [0:CORDIC_STAGES];
	prac_tag_t                     tag_c [0:CORDIC_STAGES];
	logic signed [COORD_WIDTH-1:0] bx_c [0:CORDIC_STAGES];
	logic signed [COORD_WIDTH-1:0] by_c [0:CORDIC_STAGES];

	prac_tag_t                     tag_g_q [1:GAIN_LAT];
	logic signed [COORD_WIDTH-1:0] rx_q, ry_q;
	logic                          hitx_q, hity_q;

	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && !skid_valid_q;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign feed_valid    = skid_valid_q || s_axis_tvalid;
	assign feed_data     = skid_valid_q ? skid_data_q : s_axis_tdata;
	assign feed_null     = skid_valid_q ? skid_null_q : s_axis_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && accept) begin
			skid_data_q <= s_axis_tdata;
			skid_null_q <= s_axis_tuser;
		end
	end

	prac_prerot #(.COORD_WIDTH(COORD_WIDTH)) u_prerot (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (feed_valid),
		.in_null        (feed_null),
		.point_x        (feed_data[0*COORD_WIDTH +: COORD_WIDTH]),
		.point_y        (feed_data[1*COORD_WIDTH +: COORD_WIDTH]),
		.center_x       (feed_data[2*COORD_WIDTH +: COORD_WIDTH]),
		.center_y       (feed_data[3*COORD_WIDTH +: COORD_WIDTH]),
		.rotation_angle (feed_data[4*COORD_WIDTH +: ANGLE_W]),
		.x_s1           (x_c[0]),
		.y_s1           (y_c[0]),
		.z_s1           (z_c[0]),
		.tag_s1         (tag_c[0]),
		.base_x_s1      (bx_c[0]),
		.base_y_s1      (by_c[0])
	);

	for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cell
		prac_cell #(.COORD_WIDTH(COORD_WIDTH), .IDX(gi)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.x_in      (x_c[gi]),
			.y_in      (y_c[gi]),
			.z_in      (z_c[gi]),
			.tag_in    (tag_c[gi]),
			.base_x_in (bx_c[gi]),
			.base_y_in (by_c[gi]),
			.x_q       (x_c[gi+1]),
			.y_q       (y_c[gi+1]),
			.z_q       (z_c[gi+1]),
			.tag_q     (tag_c[gi+1]),
			.base_x_q  (bx_c[gi+1]),
			.base_y_q  (by_c[gi+1])
		);
	end

	prac_gain_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
		.clk     (clk),
		.en      (en),
		.v_in    (x_c[CORDIC_STAGES]),
		.base_in (bx_c[CORDIC_STAGES]),
		.null_in (tag_c[CORDIC_STAGES].is_null),
		.val_q   (rx_q),
		.hit_q   (hitx_q)
	);

	prac_gain_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
		.clk     (clk),
		.en      (en),
		.v_in    (y_c[CORDIC_STAGES]),
		.base_in (by_c[CORDIC_STAGES]),
		.null_in (tag_c[CORDIC_STAGES].is_null),
		.val_q   (ry_q),
		.hit_q   (hity_q)
	);

	// z of the last cell is not needed downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= GAIN_LAT; k++) begin
				tag_g_q[k] <= '0;
			end
		end else if (en) begin
			tag_g_q[1] <= tag_c[CORDIC_STAGES];
			for (int k = 2; k <= GAIN_LAT; k++) begin
				tag_g_q[k] <= tag_g_q[k-1];
			end
		end
	end

	assign m_axis_tvalid = tag_g_q[GAIN_LAT].valid;
	assign m_axis_tdata  = OUT_W'({ry_q, rx_q});
	assign m_axis_tuser  = {hitx_q || hity_q, tag_g_q[GAIN_LAT].is_null};

	// residual angle of the final cell stays within one quarter turn
	assert property (@(posedge clk) disable iff (!arst_n)
		tag_c[CORDIC_STAGES].valid |->
			(z_c[CORDIC_STAGES] < $signed(32'sh4000_0000)) &&
			(z_c[CORDIC_STAGES] > $signed(-32'sh4000_0000)))
		else $error("residual angle out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && en |=> !skid_valid_q)
		else $error("skid entry not drained");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !en |=> skid_valid_q)
		else $error("stalled request not captured");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("null result flagged saturated");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			(rx_q == CMAX) || (rx_q == CMIN) || (ry_q == CMAX) || (ry_q == CMIN))
		else $error("saturated flag without clamped coordinate");

endmodule

`default_nettype wire

// File: verif/prac_checker.sv
// prac_checker: watches both stream channels of point_rotate_about_center_core,
// predicts each rotated point and compares it with the block's output.
// Depends on prac_pkg for the datapath widths and the angle and gain constants.
module prac_checker import prac_pkg::*; #(
	parameter int COORD_WIDTH   = 32,
	parameter int CORDIC_STAGES = 24,
	parameter int IN_W          = 160,
	parameter int OUT_W         = 64
) (
	input  wire logic             clk,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             s_tuser,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [OUT_W-1:0] m_tdata,
	input  wire logic [1:0]       m_tuser,
	output int                    mismatches,
	output int                    pending
);

	localparam int     GUARD     = FRAC_W - COORD_WIDTH;
	localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic [0:31][31:0] ATAN_TURNS = {
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef struct packed {
		logic [COORD_WIDTH-1:0] rot_x;
		logic [COORD_WIDTH-1:0] rot_y;
		logic                   is_null;
		logic                   sat;
	} rotated_point_t;

	rotated_point_t rotated_q[$];

	// gain compensation, then round to Q16.16 with ties away from zero
	function automatic longint scale_by_gain(input longint v);
		logic [63:0] mag, lo_prod, acc, rnd;
		mag     = (v < 0) ? -v : v;
		lo_prod = {32'd0, mag[31:0]} * {32'd0, GAIN_Q32};
		acc     = {32'd0, mag[63:32]} * {32'd0, GAIN_Q32} + (lo_prod >> 32);
		rnd     = (acc + (64'd1 << (GUARD - 1))) >> GUARD;
		return (v < 0) ? -longint'(rnd) : longint'(rnd);
	endfunction

	function automatic rotated_point_t rotate_point(input logic [IN_W-1:0] d, input logic nul);
		longint px, py, cx, cy, dx, dy, x, y, z, xs, ys, swp, sx, sy;
		logic [ANGLE_W-1:0] a;
		prac_quad_t quad;
		rotated_point_t r;
		int i;
		px = $signed(d[0 +: COORD_WIDTH]);
		py = $signed(d[COORD_WIDTH +: COORD_WIDTH]);
		cx = $signed(d[2*COORD_WIDTH +: COORD_WIDTH]);
		cy = $signed(d[3*COORD_WIDTH +: COORD_WIDTH]);
		a  = d[4*COORD_WIDTH +: ANGLE_W] + EIGHTH_TURN;
		r  = '0;
		if (nul) begin
			r.rot_x   = d[0 +: COORD_WIDTH];
			r.rot_y   = d[COORD_WIDTH +: COORD_WIDTH];
			r.is_null = 1'b1;
			return r;
		end
		dx   = px - cx;
		dy   = py - cy;
		quad = prac_quad_t'(a[31:30]);
		z    = longint'(a[29:0]) - longint'(EIGHTH_TURN);
		case (quad)
			QUAD_90: begin
				swp = dx; dx = -dy; dy = swp;
			end
			QUAD_180: begin
				dx = -dx; dy = -dy;
			end
			QUAD_270: begin
				swp = dx; dx = dy; dy = -swp;
			end
			default: ;
		endcase
		x = dx <<< GUARD;
		y = dy <<< GUARD;
		for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - longint'(ATAN_TURNS[i]);
			end else begin
				x = x + ys; y = y - xs; z = z + longint'(ATAN_TURNS[i]);
			end
		end
		sx = scale_by_gain(x) + cx;
		sy = scale_by_gain(y) + cy;
		if (sx > COORD_MAX) begin
			sx = COORD_MAX; r.sat = 1'b1;
		end else if (sx < COORD_MIN) begin
			sx = COORD_MIN; r.sat = 1'b1;
		end
		if (sy > COORD_MAX) begin
			sy = COORD_MAX; r.sat = 1'b1;
		end else if (sy < COORD_MIN) begin
			sy = COORD_MIN; r.sat = 1'b1;
		end
		r.rot_x = sx[COORD_WIDTH-1:0];
		r.rot_y = sy[COORD_WIDTH-1:0];
		return r;
	endfunction

	always @(posedge clk) begin : watch
		rotated_point_t got, want;
		if (m_tvalid && m_tready) begin
			got.rot_x   = m_tdata[0 +: COORD_WIDTH];
			got.rot_y   = m_tdata[COORD_WIDTH +: COORD_WIDTH];
			got.is_null = m_tuser[0];
			got.sat     = m_tuser[1];
			if (rotated_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: x=%h y=%h null=%b sat=%b",
						got.rot_x, got.rot_y, got.is_null, got.sat);
			end else begin
				want = rotated_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp x=%h y=%h null=%b sat=%b,",
							" got x=%h y=%h null=%b sat=%b"},
							want.rot_x, want.rot_y, want.is_null, want.sat,
							got.rot_x, got.rot_y, got.is_null, got.sat);
				end
			end
		end
		if (s_tvalid && s_tready)
			rotated_q.push_back(rotate_point(s_tdata, s_tuser));
		pending <= rotated_q.size();
	end

endmodule

// File: verif/testbench.sv
// testbench: drives point_rotate_about_center_core with directed and random
// requests under varying idle and stall patterns and reports the verdict.
// Depends on prac_pkg, the core and prac_checker.
module testbench;
	import prac_pkg::*;

	localparam int COORD_WIDTH   = 32;
	localparam int CORDIC_STAGES = 24;
	localparam int IN_W          = ((4*COORD_WIDTH + ANGLE_W + 7) / 8) * 8;
	localparam int OUT_W         = ((2*COORD_WIDTH + 7) / 8) * 8;
	localparam int DRAIN_CYCLES  = CORDIC_STAGES + 7 + 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 463;

	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [ANGLE_W-1:0] THREE_QUARTS = 32'hC000_0000;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata  = '0;
	logic             s_axis_tuser  = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [1:0]       m_axis_tuser;

	int   send_idle   = 0;
	int   recv_stall  = 0;
	logic hold_rx     = 1'b0;
	logic pressure_go = 1'b0;
	int   mismatches;
	int   pending;

	point_rotate_about_center_core #(
		.COORD_WIDTH  (COORD_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	prac_checker #(
		.COORD_WIDTH  (COORD_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES),
		.IN_W         (IN_W),
		.OUT_W        (OUT_W)
	) u_checker (
		.clk       (clk),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.s_tuser   (s_axis_tuser),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_rx)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	// long output hold-off so the pipeline fills and backs up the input
	initial begin : pressure
		wait (pressure_go);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	task automatic offer(input logic [COORD_WIDTH-1:0] px, input logic [COORD_WIDTH-1:0] py,
			input logic [COORD_WIDTH-1:0] cx, input logic [COORD_WIDTH-1:0] cy,
			input logic [ANGLE_W-1:0] ang, input logic nul);
		while ($urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_W'({ang, cy, cx, py, px});
		s_axis_tuser  <= nul;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [COORD_WIDTH-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic offer_random();
		logic [COORD_WIDTH-1:0] px, py, cx, cy, off_x, off_y;
		logic [ANGLE_W-1:0] ang;
		int kind, k;
		kind = $urandom_range(0, 99);
		cx   = $urandom;
		cy   = $urandom;
		if (kind < 35) begin
			px = $urandom;
			py = $urandom;
		end else if (kind < 75) begin
			k     = $urandom_range(0, 30);
			off_x = $urandom & ((32'd1 << k) - 1);
			off_y = $urandom & ((32'd1 << k) - 1);
			if ($urandom_range(0, 1)) off_x = -off_x;
			if ($urandom_range(0, 1)) off_y = -off_y;
			px = cx + off_x;
			py = cy + off_y;
		end else if (kind < 85) begin
			px = cx;
			py = cy;
		end else begin
			px = pick_extreme();
			py = pick_extreme();
			cx = pick_extreme();
			cy = pick_extreme();
		end
		if ($urandom_range(0, 4) == 0)
			ang = QUARTER_TURN * $urandom_range(0, 3) + EIGHTH_TURN * $urandom_range(0, 1)
				+ $urandom_range(0, 4) - 2;
		else
			ang = $urandom;
		offer(px, py, cx, cy, ang, $urandom_range(0, 99) < 8);
	endtask

	initial begin : stimulus
		int ph, n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0, 1'b0);
		offer(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0, 1'b0);
		offer(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, QUARTER_TURN, 1'b0);
		offer(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000, HALF_TURN, 1'b0);
		offer(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000, THREE_QUARTS, 1'b0);
		offer(32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, EIGHTH_TURN, 1'b0);
		offer(32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h1FFF_FFFF, 1'b0);
		offer(32'h1234_0000, 32'h0567_8000, 32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_FFFF, 1'b0);
		offer(32'h1234_0000, 32'h0567_8000, 32'hFFF0_0000, 32'h0010_0000, 32'hDFFF_FFFF, 1'b0);
		offer(32'h1234_0000, 32'h0567_8000, 32'hFFF0_0000, 32'h0010_0000, 32'h6000_0000, 1'b0);
		// zero offset: result is the center
		offer(32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321, 32'h3333_3333, 1'b0);
		offer(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hA5A5_A5A5, 1'b0);
		// null point passes through
		offer(32'h7FFF_FFFF, 32'h8000_0000, 32'h1357_9BDF, 32'h2468_ACE0, 32'h5A5A_5A5A, 1'b1);
		offer(32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		// widest offsets, saturation
		offer(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0);
		offer(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, HALF_TURN, 1'b0);
		offer(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, HALF_TURN, 1'b0);
		offer(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h1000_0000, 1'b0);
		offer(32'h7FFF_0000, 32'h7FFF_0000, 32'h0000_0000, 32'h0000_0000, EIGHTH_TURN, 1'b0);
		offer(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'hAAAA_AAAA, 1'b0);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle <= 0; recv_stall <= 0;
				end
				1: begin
					send_idle <= 49; recv_stall <= 0;
				end
				2: begin
					send_idle <= 0; recv_stall <= 49;
				end
				default: begin
					send_idle <= 9; recv_stall <= 9;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 120)
					pressure_go <= 1'b1;
				offer_random();
			end
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: files.f
rtl/core/prac_pkg.sv
rtl/core/prac_prerot.sv
rtl/core/prac_cell.sv
rtl/core/prac_gain_lane.sv
rtl/core/point_rotate_about_center_core.sv
verif/prac_checker.sv
verif/testbench.sv
